>>> rtl/sbpe_pkg.sv
// sbpe_pkg: shared constants, codes and controller/datapath link types
// for the swap-and-backtrack permutation enumerator; no dependencies
`timescale 1ns / 1ps

package sbpe_pkg;

  // list geometry
  localparam int MAX_ELEMENTS = 8;
  localparam int ELEMENT_BITS = 8;
  localparam int IDX_W        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  // fixed field widths
  localparam int OP_W   = 2;
  localparam int SLOT_W = 3;
  localparam int VAL_W  = 8;
  localparam int CNT_W  = 4;
  localparam int CUR_W  = 4;
  localparam int LANE_W = 8;
  localparam int WORD_W = 64;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
  localparam logic [OP_W-1:0] OP_NEXT    = 2'd2;

  // result kinds loaded into the output register
  typedef logic [1:0] res_kind_t;
  localparam res_kind_t RES_STATUS  = 2'd0;
  localparam res_kind_t RES_RESTART = 2'd1;
  localparam res_kind_t RES_PERM    = 2'd2;
  localparam res_kind_t RES_END     = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic      load_we;
    logic      swap_undo;
    logic      clear;
    logic      first;
    logic      step;
    logic      redo;
    logic      fail;
    logic      res_en;
    res_kind_t res;
  } sbpe_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic started;
    logic exhausted;
    logic level_zero;
    logic step_hit;
    logic out_free;
  } sbpe_sts_t;

endpackage

>>> rtl/sbpe_if.sv
// sbpe_in_if / sbpe_out_if: valid/ready channels of the enumerator
// depends on sbpe_pkg for field widths
`timescale 1ns / 1ps

interface sbpe_in_if import sbpe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [SLOT_W-1:0] slot;
  logic [VAL_W-1:0]  value;

  modport source (output valid, operation, slot, value, input ready);
  modport sink   (input valid, operation, slot, value, output ready);
endinterface

interface sbpe_out_if import sbpe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] perm_word;
  logic              perm_valid;
  logic              finished;

  modport source (output valid, perm_word, perm_valid, finished, input ready);
  modport sink   (input valid, perm_word, perm_valid, finished, output ready);
endinterface

>>> rtl/swap_backtrack_permutation_enumerator.sv
// swap_backtrack_permutation_enumerator: top level, channel wiring
// depends on sbpe_pkg, sbpe_if, sbpe_ctrl and sbpe_dpath
`timescale 1ns / 1ps

// Walks the orderings of a loaded list of up to MAX_ELEMENTS bytes in the
// order of the recursive swap-and-backtrack scheme, one leaf per next
// transaction, with one result transaction for every input transaction.
// The level stack is unwound and re-applied one swap per clock by a single
// swap unit on the element registers, so timing follows the stack depth:
// a load or no-op transaction puts its result in the output register at
// the accepting edge; the first next after a restart passes through the
// delivery state, a later next through the unwind steps, the forward swap
// and delivery, and a next after the end answers at the accepting edge; a
// restart undoes the applied swaps level by level, clears the stack and
// delivers. Writing the element count also restarts: the input stays
// not-ready after the write while the same unwind runs. A new transaction is
// taken once the block is back in its idle state, no count write is pending
// and the output register is empty or is being read in the same cycle.
module swap_backtrack_permutation_enumerator import sbpe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  sbpe_in_if.sink          in_ch,
  sbpe_out_if.source       out_ch
);

  sbpe_cmd_t cmd;
  sbpe_sts_t sts;
  logic      in_ready;
  logic      out_valid;

  // sequencer
  sbpe_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ready),
    .in_operation (in_ch.operation),
    .cmd          (cmd),
    .sts          (sts)
  );

  // store, level stack and output register
  sbpe_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_slot        (in_ch.slot),
    .in_value       (in_ch.value),
    .out_valid      (out_valid),
    .out_ready      (out_ch.ready),
    .out_perm_word  (out_ch.perm_word),
    .out_perm_valid (out_ch.perm_valid),
    .out_finished   (out_ch.finished),
    .cmd            (cmd),
    .sts            (sts)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

>>> rtl/sbpe_dpath.sv
// sbpe_dpath: element store, level stack, one swap per cycle, output register
// depends on sbpe_pkg; driven by sbpe_ctrl commands
`timescale 1ns / 1ps

module sbpe_dpath import sbpe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic [VAL_W-1:0]  in_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_perm_word,
  output logic              out_perm_valid,
  output logic              out_finished,
  input  sbpe_cmd_t         cmd,
  output sbpe_sts_t         sts
);

  logic [ELEMENT_BITS-1:0] store_r [MAX_ELEMENTS];
  logic [CUR_W-1:0]        cur_r   [MAX_ELEMENTS];
  logic [CUR_W-1:0]        cur_nxt [MAX_ELEMENTS];
  logic [CUR_W-1:0]        level_r, level_nxt;
  logic                    started_r, started_nxt;
  logic                    exhausted_r, exhausted_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    out_valid_r;
  logic [WORD_W-1:0]       out_word_r;
  logic                    out_perm_r;
  logic                    out_fin_r;

  logic [CUR_W-1:0]  n_use;
  logic [CUR_W-1:0]  a_lvl;
  logic [IDX_W-1:0]  idx_a;
  logic [IDX_W-1:0]  idx_b;
  logic [CUR_W-1:0]  cur_a;
  logic              b_ok;
  logic              do_swap;
  logic              load_hit;
  logic [CUR_W-1:0]  desc_from;
  logic              at_last;
  logic [WORD_W-1:0] packed_word;

  // elements in use, clamped to 1..MAX_ELEMENTS
  always_comb begin
    if (count_r == '0) begin
      n_use = CUR_W'(1);
    end else if (count_r > CNT_W'(MAX_ELEMENTS)) begin
      n_use = CUR_W'(MAX_ELEMENTS);
    end else begin
      n_use = CUR_W'(count_r);
    end
  end

  // swap operands: level s for the forward swap, s-1 while unwinding
  always_comb begin
    a_lvl    = cmd.redo ? level_r : (level_r - CUR_W'(1));
    idx_a    = a_lvl[IDX_W-1:0];
    cur_a    = cur_r[idx_a];
    b_ok     = (cur_a < CUR_W'(MAX_ELEMENTS));
    idx_b    = cur_a[IDX_W-1:0];
    do_swap  = (cmd.swap_undo | cmd.step | cmd.redo) & b_ok;
    load_hit = cmd.load_we & ({1'b0, in_slot} < (SLOT_W + 1)'(MAX_ELEMENTS));
  end

  // last leaf check and packed word, one lane per element
  always_comb begin
    at_last     = 1'b1;
    packed_word = '0;
    for (int k = 0; k < MAX_ELEMENTS; k++) begin
      if ((CUR_W'(k) + CUR_W'(1) < n_use) && (cur_r[k] != n_use - CUR_W'(1))) begin
        at_last = 1'b0;
      end
      if (CUR_W'(k) < n_use) begin
        packed_word[k*LANE_W +: LANE_W] = LANE_W'(store_r[k]);
      end
    end
  end

  // element store: load writes, swaps exchange two entries
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_ELEMENTS; k++) begin
      if (load_hit && (in_slot[IDX_W-1:0] == IDX_W'(k))) begin
        store_r[k] <= in_value[ELEMENT_BITS-1:0];
      end else if (do_swap && (idx_a == IDX_W'(k))) begin
        store_r[k] <= store_r[idx_b];
      end else if (do_swap && (idx_b == IDX_W'(k))) begin
        store_r[k] <= store_r[idx_a];
      end
    end
  end

  // level stack next state
  always_comb begin
    cur_nxt       = cur_r;
    level_nxt     = level_r;
    started_nxt   = started_r;
    exhausted_nxt = exhausted_r;
    count_nxt     = cfg_wr_en ? cfg_wr_data : count_r;
    desc_from     = cmd.first ? '0 : (level_r + CUR_W'(1));

    if (cmd.clear) begin
      for (int k = 0; k < MAX_ELEMENTS; k++) begin
        cur_nxt[k] = '0;
      end
      level_nxt     = '0;
      started_nxt   = 1'b0;
      exhausted_nxt = 1'b0;
    end
    if (cmd.fail) begin
      level_nxt     = '0;
      started_nxt   = 1'b0;
      exhausted_nxt = 1'b1;
    end
    if (cmd.swap_undo) begin
      level_nxt = level_r - CUR_W'(1);
    end
    if (cmd.step) begin
      cur_nxt[idx_a] = cur_a + CUR_W'(1);
      level_nxt      = a_lvl;
    end
    // descend: each deeper level starts with its own position
    if (cmd.first || cmd.redo) begin
      for (int k = 0; k < MAX_ELEMENTS; k++) begin
        if ((CUR_W'(k) >= desc_from) && (CUR_W'(k) + CUR_W'(1) < n_use)) begin
          cur_nxt[k] = CUR_W'(k);
        end
      end
      level_nxt = n_use - CUR_W'(1);
      if (cmd.first) begin
        started_nxt = 1'b1;
      end
    end
    if (cmd.res_en && (cmd.res == RES_PERM)) begin
      exhausted_nxt = at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_ELEMENTS; k++) begin
        cur_r[k] <= '0;
      end
      level_r     <= '0;
      started_r   <= 1'b0;
      exhausted_r <= 1'b0;
      count_r     <= CNT_W'(8);
    end else begin
      cur_r       <= cur_nxt;
      level_r     <= level_nxt;
      started_r   <= started_nxt;
      exhausted_r <= exhausted_nxt;
      count_r     <= count_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_en) begin
      case (cmd.res)
        RES_PERM: begin
          out_word_r <= packed_word;
          out_perm_r <= 1'b1;
          out_fin_r  <= at_last;
        end
        RES_END: begin
          out_word_r <= '0;
          out_perm_r <= 1'b0;
          out_fin_r  <= 1'b1;
        end
        RES_RESTART: begin
          out_word_r <= '0;
          out_perm_r <= 1'b0;
          out_fin_r  <= 1'b0;
        end
        default: begin
          out_word_r <= '0;
          out_perm_r <= 1'b0;
          out_fin_r  <= exhausted_r;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_perm_word  = out_word_r;
  assign out_perm_valid = out_perm_r;
  assign out_finished   = out_fin_r;

  // status to the controller
  always_comb begin
    sts.started    = started_r;
    sts.exhausted  = exhausted_r;
    sts.level_zero = (level_r == '0);
    sts.step_hit   = ((cur_a + CUR_W'(1)) < n_use);
    sts.out_free   = !out_valid_r || out_ready;
  end

  // a permutation is only reported from a leaf
  a_perm_at_leaf: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.res_en && (cmd.res == RES_PERM)) |-> (level_r == n_use - CUR_W'(1)))
    else $error("permutation reported away from a leaf");

  // the level pointer stays within the stack
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r < CUR_W'(MAX_ELEMENTS))
    else $error("level pointer beyond the stack");

  // an end result only after the enumeration is marked exhausted
  a_end_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.res_en && (cmd.res == RES_END)) |-> exhausted_r)
    else $error("end result without exhausted state");

endmodule

>>> rtl/sbpe_ctrl.sv
// sbpe_ctrl: sequencer for load, restart unwind and leaf advance
// depends on sbpe_pkg; commands sbpe_dpath
`timescale 1ns / 1ps

module sbpe_ctrl import sbpe_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [OP_W-1:0] in_operation,
  output sbpe_cmd_t       cmd,
  input  sbpe_sts_t       sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UNDO = 3'd1;
  localparam logic [2:0] S_STEP = 3'd2;
  localparam logic [2:0] S_REDO = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  res_kind_t  res_kind_r, res_kind_nxt;
  logic       via_cfg_r, via_cfg_nxt;
  logic       cfg_pend_r, cfg_pend_nxt;
  logic       accept;

  // next-state and command decode
  always_comb begin
    state_nxt    = state_r;
    res_kind_nxt = res_kind_r;
    via_cfg_nxt  = via_cfg_r;
    cmd          = '0;
    in_ready     = (state_r == S_IDLE) && !cfg_pend_r && !cfg_wr_en && sts.out_free;
    accept       = in_valid && in_ready;
    // a count write restarts; it waits for the idle state
    cfg_pend_nxt = cfg_wr_en | (cfg_pend_r & (state_r != S_IDLE));

    case (state_r)
      S_IDLE: begin
        if (cfg_pend_r) begin
          state_nxt   = S_UNDO;
          via_cfg_nxt = 1'b1;
        end else if (accept) begin
          case (in_operation)
            OP_LOAD: begin
              cmd.load_we = 1'b1;
              cmd.res_en  = 1'b1;
              cmd.res     = RES_STATUS;
            end
            OP_RESTART: begin
              state_nxt   = S_UNDO;
              via_cfg_nxt = 1'b0;
            end
            OP_NEXT: begin
              if (sts.exhausted) begin
                cmd.res_en = 1'b1;
                cmd.res    = RES_END;
              end else if (!sts.started) begin
                cmd.first    = 1'b1;
                res_kind_nxt = RES_PERM;
                state_nxt    = S_DONE;
              end else begin
                state_nxt = S_STEP;
              end
            end
            default: begin
              cmd.res_en = 1'b1;
              cmd.res    = RES_STATUS;
            end
          endcase
        end
      end
      // undo applied swaps from the deepest level up, then clear
      S_UNDO: begin
        if (sts.started && !sts.level_zero) begin
          cmd.swap_undo = 1'b1;
        end else begin
          cmd.clear = 1'b1;
          if (via_cfg_r) begin
            state_nxt = S_IDLE;
          end else begin
            res_kind_nxt = RES_RESTART;
            state_nxt    = S_DONE;
          end
        end
      end
      // unwind one level: swap back and move its cursor on
      S_STEP: begin
        if (sts.level_zero) begin
          cmd.fail     = 1'b1;
          res_kind_nxt = RES_END;
          state_nxt    = S_DONE;
        end else begin
          cmd.step = 1'b1;
          if (sts.step_hit) begin
            state_nxt = S_REDO;
          end
        end
      end
      // apply the new swap and descend to the leaf
      S_REDO: begin
        cmd.redo     = 1'b1;
        res_kind_nxt = RES_PERM;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.res_en = 1'b1;
          cmd.res    = res_kind_r;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      res_kind_r <= RES_STATUS;
      via_cfg_r  <= 1'b0;
      cfg_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      res_kind_r <= res_kind_nxt;
      via_cfg_r  <= via_cfg_nxt;
      cfg_pend_r <= cfg_pend_nxt;
    end
  end

  // unwinding only happens inside a started enumeration
  a_step_started: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP) |-> sts.started)
    else $error("unwind step outside an enumeration");

  // a result is never loaded over one that is still waiting
  a_res_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_en |-> sts.out_free)
    else $error("result loaded into a full output register");

  // the forward swap is followed by delivery
  a_redo_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REDO) |=> (state_r == S_DONE))
    else $error("forward swap not followed by delivery");

endmodule

>>> sim/tb.sv
// tb: self-checking testbench for swap_backtrack_permutation_enumerator
// depends on sbpe_pkg, sbpe_if and the enumerator rtl; predicts every result
// transaction from its own copy of the level stack and checks it in order
`timescale 1ns / 1ps

module tb;
  import sbpe_pkg::*;

  // operation code 3 is unused by the block and must change nothing
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;
  localparam int RANDOM_ITEMS = 1550;
  localparam int MAX_WAIT     = 12;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 500000;

  // predictor of the enumerator plus the queue of arrangements still owed
  class perm_scoreboard;
    typedef struct {
      logic [WORD_W-1:0] word;
      logic              perm_valid;
      logic              finished;
    } arrangement_t;

    arrangement_t            expected_perms[$];
    logic [ELEMENT_BITS-1:0] lanes[MAX_ELEMENTS];
    logic [CUR_W-1:0]        cursor[MAX_ELEMENTS];
    logic [CUR_W-1:0]        level;
    logic [CNT_W-1:0]        count;
    bit                      exhausted;
    bit                      started;
    int                      errors;

    function new();
      for (int s = 0; s < MAX_ELEMENTS; s++) begin
        lanes[s]  = '0;
        cursor[s] = '0;
      end
      level     = '0;
      count     = CNT_W'(MAX_ELEMENTS);
      exhausted = 0;
      started   = 0;
      errors    = 0;
    endfunction

    // zero acts as one, anything past the store acts as full size
    function int unsigned used_count();
      if (count == 0) return 1;
      if (count > MAX_ELEMENTS) return MAX_ELEMENTS;
      return count;
    endfunction

    function void swap_lanes(int unsigned a, int unsigned b);
      logic [ELEMENT_BITS-1:0] t;
      if (a >= MAX_ELEMENTS || b >= MAX_ELEMENTS) return;
      t        = lanes[a];
      lanes[a] = lanes[b];
      lanes[b] = t;
    endfunction

    // undo applied swaps deepest first, then clear the stack
    function void unwind();
      if (started) begin
        for (int unsigned s = level; s > 0 && s <= MAX_ELEMENTS; s--)
          swap_lanes(s - 1, cursor[s - 1]);
      end
      for (int s = 0; s < MAX_ELEMENTS; s++) cursor[s] = '0;
      level     = '0;
      started   = 0;
      exhausted = 0;
    endfunction

    function void descend_from(int unsigned from, int unsigned n);
      for (int unsigned s = from; s + 1 < n; s++) cursor[s] = CUR_W'(s);
      level = CUR_W'(n - 1);
    endfunction

    // move to the following leaf, 0 once the tree is used up
    function bit step_leaf(int unsigned n);
      int unsigned s;
      if (!started) begin
        descend_from(0, n);
        started = 1;
        return 1;
      end
      s = level;
      if (s > MAX_ELEMENTS) s = MAX_ELEMENTS;
      while (s > 0) begin
        s--;
        swap_lanes(s, cursor[s]);
        cursor[s]++;
        if (cursor[s] < n) begin
          swap_lanes(s, cursor[s]);
          descend_from(s + 1, n);
          return 1;
        end
      end
      level     = '0;
      started   = 0;
      exhausted = 1;
      return 0;
    endfunction

    function bit on_last_leaf(int unsigned n);
      for (int unsigned s = 0; s + 1 < n; s++)
        if (cursor[s] != n - 1) return 0;
      return 1;
    endfunction

    // a count write also restarts the walk
    function void write_count(logic [CNT_W-1:0] v);
      unwind();
      count = v;
    endfunction

    function void note_item(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                            logic [VAL_W-1:0] value);
      arrangement_t r;
      int unsigned  n;
      n            = used_count();
      r.word       = '0;
      r.perm_valid = 0;
      r.finished   = exhausted;
      case (op)
        OP_LOAD: begin
          if (slot < MAX_ELEMENTS)
            lanes[slot] = ELEMENT_BITS'(value & VAL_W'((1 << ELEMENT_BITS) - 1));
        end
        OP_RESTART: begin
          unwind();
          r.finished = 0;
        end
        OP_NEXT: begin
          if (exhausted || !step_leaf(n)) begin
            r.finished = 1;
          end else begin
            for (int unsigned k = 0; k < n; k++)
              r.word[LANE_W*k +: LANE_W] = LANE_W'(lanes[k]);
            exhausted    = on_last_leaf(n);
            r.perm_valid = 1;
            r.finished   = exhausted;
          end
        end
        default: ;
      endcase
      expected_perms = {expected_perms, r};
    endfunction

    function int pending();
      return expected_perms.size();
    endfunction

    function void check_item(logic [WORD_W-1:0] word, logic perm_valid, logic finished);
      arrangement_t r;
      if (expected_perms.size() == 0) begin
        $display("%0t: result transaction with nothing expected: word %h valid %b fin %b",
                 $time, word, perm_valid, finished);
        errors++;
        return;
      end
      r = expected_perms.pop_front();
      if (word !== r.word) begin
        $display("%0t: perm_word mismatch: expected %h, actual %h", $time, r.word, word);
        errors++;
      end
      if (perm_valid !== r.perm_valid) begin
        $display("%0t: perm_valid mismatch: expected %b, actual %b",
                 $time, r.perm_valid, perm_valid);
        errors++;
      end
      if (finished !== r.finished) begin
        $display("%0t: finished mismatch: expected %b, actual %b",
                 $time, r.finished, finished);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;
  bit               calm = 0;
  int               items_sent = 0;
  int               cycle_count;

  sbpe_in_if  in_ch();
  sbpe_out_if out_ch();

  perm_scoreboard perms = new();

  swap_backtrack_permutation_enumerator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always #5 clk = ~clk;

  // per-item wait, none during calm phases
  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // offer one input transaction and note it once accepted
  task automatic send_item(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                           input logic [VAL_W-1:0] value);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.slot      <= slot;
    in_ch.value     <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    perms.note_item(op, slot, value);
    items_sent++;
  endtask

  // stop offering and wait for every owed result
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (perms.pending() != 0) @(posedge clk);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    perms.write_count(v);
    cfg_wr_en <= 1'b0;
  endtask

  // result side: random stalls, check each accepted transaction
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = draw_wait();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      perms.check_item(out_ch.perm_word, out_ch.perm_valid, out_ch.finished);
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** swap_backtrack_permutation_enumerator: FAILED **");
    $finish;
  end

  // stimulus
  initial begin
    logic [VAL_W-1:0] first_list[MAX_ELEMENTS];
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] value;
    int               cnt;
    int               len;
    int               pick;
    int               phase;
    int               random_goal;

    first_list = '{8'h00, 8'h81, 8'h42, 8'hC3, 8'h24, 8'hA5, 8'h7E, 8'hFF};
    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= '0;
    in_ch.slot      <= '0;
    in_ch.value     <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // fill every slot before any arrangement is read
    for (int i = 0; i < MAX_ELEMENTS; i++)
      send_item(OP_LOAD, SLOT_W'(i), first_list[i]);
    send_item(OP_NOP, 3'd5, 8'hFF);

    // single element list: one arrangement, it is the last, then nothing left
    write_count(4'd1);
    send_item(OP_NEXT, 3'd0, 8'h00);
    send_item(OP_NEXT, 3'd7, 8'hFF);
    send_item(OP_NOP, 3'd2, 8'h3C);
    send_item(OP_LOAD, 3'd0, 8'h99);
    send_item(OP_RESTART, 3'd6, 8'h18);

    // three elements: load mid-walk, restart undoes swaps, full walk and beyond
    write_count(4'd3);
    send_item(OP_NEXT, 3'd1, 8'h00);
    send_item(OP_LOAD, 3'd2, 8'hFF);
    send_item(OP_NEXT, 3'd0, 8'h00);
    send_item(OP_RESTART, 3'd0, 8'h00);
    repeat (7) send_item(OP_NEXT, 3'd0, 8'h00);

    // random phases, each with its own count; extremes come first
    random_goal = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < random_goal) begin
      case (phase)
        0: cnt = 0;
        1: cnt = 15;
        2: cnt = 8;
        3: cnt = 2;
        default: cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                   : $urandom_range(1, 5);
      endcase
      write_count(CNT_W'(cnt));
      calm = ($urandom_range(0, 3) == 0);
      len  = $urandom_range(20, 140);
      repeat (len) begin
        pick = $urandom_range(0, 99);
        if (pick < 78)      op = OP_NEXT;
        else if (pick < 88) op = OP_LOAD;
        else if (pick < 94) op = OP_RESTART;
        else                op = OP_NOP;
        value = VAL_W'($urandom);
        if ($urandom_range(0, 7) == 0) value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        send_item(op, SLOT_W'($urandom_range(0, MAX_ELEMENTS - 1)), value);
      end
      phase++;
    end

    // drain, then let any stray result show up
    calm = 0;
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (perms.errors == 0 && perms.pending() == 0)
      $display("** swap_backtrack_permutation_enumerator: PASSED **");
    else
      $display("** swap_backtrack_permutation_enumerator: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
rtl/sbpe_pkg.sv
rtl/sbpe_if.sv
rtl/sbpe_dpath.sv
rtl/sbpe_ctrl.sv
rtl/swap_backtrack_permutation_enumerator.sv
sim/tb.sv
